FILE: rtl/core/pcadj_pkg.sv
// Shared types, constants and clamp helpers for the pixel contrast adjust block.
`default_nettype none

package pcadj_pkg;

    // Pipeline depth: four arithmetic stages plus the output register.
    localparam int NumStages = 5;

    // Configuration port widths.
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        REG_COLOR_MODE   = 2'd0,
        REG_LEVEL_OFFSET = 2'd1,
        REG_GAIN         = 2'd2
    } cfg_reg_t;

    // Color mode codes.
    localparam logic MODE_RGB   = 1'b0;
    localparam logic MODE_YCBCR = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] GainUnity = 16'd256;

    // Forward BT.601 luma coefficients, Q2.14, summing to 2^14.
    localparam logic [21:0] CoefYr = 22'd4899;
    localparam logic [21:0] CoefYg = 22'd9617;
    localparam logic [21:0] CoefYb = 22'd1868;

    // Chroma scale factors 1/1.772 and 1/1.402, Q2.14.
    localparam logic signed [14:0] CoefCb = 15'sd9246;
    localparam logic signed [14:0] CoefCr = 15'sd11686;

    // Inverse coefficients, Q2.14.
    localparam logic signed [15:0] CoefRcr = 16'sd22970;
    localparam logic signed [15:0] CoefGcr = 16'sd11700;
    localparam logic signed [15:0] CoefGcb = 16'sd5638;
    localparam logic signed [15:0] CoefBcb = 16'sd29032;

    // Chroma offset 127.5 in Q.28 and the clamp tops of each format.
    localparam logic signed [39:0] Half28 = 40'sd34225520640;
    localparam logic signed [39:0] Top28  = 40'sd68451041280;
    localparam logic signed [26:0] Top15  = 27'sd8355840;
    localparam logic signed [26:0] Top8   = 27'sd65280;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic              color_mode;
        logic signed [8:0] level_offset;
        logic [15:0]       gain_q8_8;
    } cfg_t;

    // Input and output beats.
    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_pix_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } out_pix_t;

    // Per-stage pipeline control: load enables and valid flags.
    typedef struct packed {
        logic [NumStages-1:0] adv;
        logic [NumStages-1:0] vld;
    } pipe_ctl_t;

    // Clamp a Q.8 value to 0..255 and truncate.
    function automatic logic [7:0] clamp_q8(input logic signed [26:0] p);
        logic [7:0] res;
        if (p < 0)
            res = 8'd0;
        else if (p > Top8)
            res = 8'd255;
        else
            res = p[15:8];
        return res;
    endfunction

    // Clamp a Q.15 value to 0..255 and truncate.
    function automatic logic [7:0] clamp_q15(input logic signed [26:0] p);
        logic [7:0] res;
        if (p < 0)
            res = 8'd0;
        else if (p > Top15)
            res = 8'd255;
        else
            res = p[22:15];
        return res;
    endfunction

    // Clamp a Q.28 value to 0..255 and truncate.
    function automatic logic [7:0] clamp_q28(input logic signed [39:0] p);
        logic [7:0] res;
        if (p < 0)
            res = 8'd0;
        else if (p > Top28)
            res = 8'd255;
        else
            res = p[35:28];
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/pcadj_cfg_regs.sv
// Configuration register file for the pixel contrast adjust block.
`default_nettype none

module pcadj_cfg_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pcadj_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [pcadj_pkg::CfgDataW-1:0] cfg_wdata,
    output pcadj_pkg::cfg_t                     cfg
);
    import pcadj_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; unknown indexes leave the registers alone.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLOR_MODE:   cfg_next.color_mode   = cfg_wdata[0];
                REG_LEVEL_OFFSET: cfg_next.level_offset = $signed(cfg_wdata[8:0]);
                REG_GAIN:         cfg_next.gain_q8_8    = cfg_wdata[15:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.color_mode   <= MODE_RGB;
            cfg_reg.level_offset <= 9'sd0;
            cfg_reg.gain_q8_8    <= GainUnity;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pcadj_pipe_ctrl.sv
// Valid tracking and per-stage load enables for the pixel pipeline.
`default_nettype none

module pcadj_pipe_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             out_ready,
    output pcadj_pkg::pipe_ctl_t  ctl
);
    import pcadj_pkg::*;

    logic [NumStages-1:0] vld_reg;
    logic [NumStages-1:0] vld_next;
    logic [NumStages-1:0] adv;

    // A stage loads when it is empty or its contents move on, so bubbles collapse.
    always_comb
    begin
        adv[NumStages-1] = !vld_reg[NumStages-1] || out_ready;
        for (int k = NumStages - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    // Valid flags follow the data through each loading stage.
    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
            vld_next[0] = in_valid;
        for (int k = 1; k < NumStages; k++)
        begin
            if (adv[k])
                vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign ctl.adv = adv;
    assign ctl.vld = vld_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pcadj_datapath.sv
// Five-stage arithmetic pipeline: color conversion, contrast and clamping.
`default_nettype none

module pcadj_datapath (
    input  wire logic                  clk,
    input  wire pcadj_pkg::cfg_t       cfg,
    input  wire pcadj_pkg::pipe_ctl_t  ctl,
    input  wire pcadj_pkg::in_pix_t    in_data,
    output pcadj_pkg::out_pix_t        out_data
);
    import pcadj_pkg::*;

    // Stage 1: luma sum and per-channel offset removal.
    logic [7:0]        s1_r_reg, s1_b_reg;
    logic [21:0]       s1_ya_reg;
    logic signed [9:0] s1_dr_reg, s1_dg_reg, s1_db_reg;
    logic [21:0]       s1_ya_next;
    logic signed [9:0] off10;

    // Stage 2: luma, chroma products and RGB contrast products.
    logic [7:0]         s2_y_reg;
    logic signed [37:0] s2_cbp_reg, s2_crp_reg;
    logic signed [26:0] s2_pr_reg, s2_pg_reg, s2_pb_reg;
    logic signed [22:0] s2_db_next, s2_dr_next;
    logic signed [16:0] gain17;

    // Stage 3: clamped chroma, luma contrast product, RGB results.
    logic [7:0]         s3_cb_reg, s3_cr_reg;
    logic signed [26:0] s3_yp_reg;
    logic [7:0]         s3_ro_reg, s3_go_reg, s3_bo_reg;
    logic signed [9:0]  s3_ydiff;

    // Stage 4: adjusted luma and inverse chroma products.
    logic [7:0]         s4_y2_reg;
    logic signed [25:0] s4_rcr_reg, s4_gcr_reg, s4_gcb_reg, s4_bcb_reg;
    logic [7:0]         s4_ro_reg, s4_go_reg, s4_bo_reg;
    logic signed [9:0]  s4_dcr, s4_dcb;

    // Stage 5: output register.
    out_pix_t           s5_out_reg;
    out_pix_t           s5_out_next;
    logic signed [26:0] y15;
    logic signed [26:0] sum_r, sum_g, sum_b;

    assign off10  = {cfg.level_offset[8], cfg.level_offset};
    assign gain17 = $signed({1'b0, cfg.gain_q8_8});

    // Luma as a weighted sum of the three channels, Q.14.
    assign s1_ya_next = 22'(in_data.in_red)   * CoefYr
                      + 22'(in_data.in_green) * CoefYg
                      + 22'(in_data.in_blue)  * CoefYb;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[0])
        begin
            s1_r_reg  <= in_data.in_red;
            s1_b_reg  <= in_data.in_blue;
            s1_ya_reg <= s1_ya_next;
            s1_dr_reg <= $signed({2'b00, in_data.in_red})   - off10;
            s1_dg_reg <= $signed({2'b00, in_data.in_green}) - off10;
            s1_db_reg <= $signed({2'b00, in_data.in_blue})  - off10;
        end
    end

    // Color differences against luma, both Q.14.
    assign s2_db_next = $signed({1'b0, s1_b_reg, 14'd0}) - $signed({1'b0, s1_ya_reg});
    assign s2_dr_next = $signed({1'b0, s1_r_reg, 14'd0}) - $signed({1'b0, s1_ya_reg});

    always_ff @(posedge clk)
    begin
        if (ctl.adv[1])
        begin
            // Luma never exceeds 255 in Q.14, so truncation alone suffices.
            s2_y_reg   <= s1_ya_reg[21:14];
            s2_cbp_reg <= s2_db_next * CoefCb;
            s2_crp_reg <= s2_dr_next * CoefCr;
            s2_pr_reg  <= s1_dr_reg * gain17;
            s2_pg_reg  <= s1_dg_reg * gain17;
            s2_pb_reg  <= s1_db_reg * gain17;
        end
    end

    assign s3_ydiff = $signed({2'b00, s2_y_reg}) - off10;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[2])
        begin
            s3_cb_reg <= clamp_q28(40'(s2_cbp_reg) + Half28);
            s3_cr_reg <= clamp_q28(40'(s2_crp_reg) + Half28);
            s3_yp_reg <= s3_ydiff * gain17;
            s3_ro_reg <= clamp_q8(s2_pr_reg);
            s3_go_reg <= clamp_q8(s2_pg_reg);
            s3_bo_reg <= clamp_q8(s2_pb_reg);
        end
    end

    // Chroma back to signed differences around the midpoint, doubled.
    assign s4_dcr = $signed({1'b0, s3_cr_reg, 1'b0}) - 10'sd255;
    assign s4_dcb = $signed({1'b0, s3_cb_reg, 1'b0}) - 10'sd255;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[3])
        begin
            s4_y2_reg  <= clamp_q8(s3_yp_reg);
            s4_rcr_reg <= s4_dcr * CoefRcr;
            s4_gcr_reg <= s4_dcr * CoefGcr;
            s4_gcb_reg <= s4_dcb * CoefGcb;
            s4_bcb_reg <= s4_dcb * CoefBcb;
            s4_ro_reg  <= s3_ro_reg;
            s4_go_reg  <= s3_go_reg;
            s4_bo_reg  <= s3_bo_reg;
        end
    end

    // Inverse conversion in Q.15 and the mode select.
    assign y15   = $signed({4'd0, s4_y2_reg, 15'd0});
    assign sum_r = y15 + 27'(s4_rcr_reg);
    assign sum_g = y15 - 27'(s4_gcr_reg) - 27'(s4_gcb_reg);
    assign sum_b = y15 + 27'(s4_bcb_reg);

    always_comb
    begin
        if (cfg.color_mode == MODE_YCBCR)
        begin
            s5_out_next.out_red   = clamp_q15(sum_r);
            s5_out_next.out_green = clamp_q15(sum_g);
            s5_out_next.out_blue  = clamp_q15(sum_b);
        end
        else
        begin
            s5_out_next.out_red   = s4_ro_reg;
            s5_out_next.out_green = s4_go_reg;
            s5_out_next.out_blue  = s4_bo_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[4])
            s5_out_reg <= s5_out_next;
    end

    assign out_data = s5_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/pixel_contrast_adjust_rgb_ycbcr.sv
// Top level of the pixel contrast adjust block with RGB or BT.601 luma mode.
//
// One 8-bit RGB pixel enters per input beat (in_valid/in_ready, payload
// in_data) and one adjusted pixel leaves per output beat (out_valid/
// out_ready, payload out_data). Each channel, or the full-range BT.601 luma
// in YCbCr mode, becomes clamp((v - level_offset) * gain_q8_8 / 256, 0, 255).
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata; write them
// only while no pixel is in flight.
// An accepted input beat reaches out_valid through the five register stages
// (luma sum, chroma and contrast products, chroma clamp and luma product,
// inverse products, output register).
// Throughput is one pixel per cycle while out_ready is high. When the
// receiver holds out_ready low, the output stage keeps its beat and the
// earlier stages fill until all five hold a pixel; only then in_ready drops.
// Reset clears all valid flags and loads color_mode 0, level_offset 0 and
// gain_q8_8 256 (unity gain, RGB mode).
`default_nettype none

module pixel_contrast_adjust_rgb_ycbcr (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_wr_en,
    input  wire logic [pcadj_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [pcadj_pkg::CfgDataW-1:0] cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire pcadj_pkg::in_pix_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output pcadj_pkg::out_pix_t                 out_data
);
    import pcadj_pkg::*;

    cfg_t      cfg;
    pipe_ctl_t ctl;

    pcadj_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pcadj_pipe_ctrl u_pipe_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    pcadj_datapath u_datapath (
        .clk      (clk),
        .cfg      (cfg),
        .ctl      (ctl),
        .in_data  (in_data),
        .out_data (out_data)
    );

    assign in_ready  = ctl.adv[0];
    assign out_valid = ctl.vld[NumStages-1];

    // An empty output stage means every stage can load, so input is open.
    a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked while output stage is empty");

    // Input backpressure only when every stage holds a pixel.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (ctl.vld == '1))
        else $error("input blocked with a bubble in the pipeline");

    // A new output beat must come from the stage just before the output.
    a_out_from_prev: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctl.vld[NumStages-2]))
        else $error("output valid without a pixel in the previous stage");

endmodule

`default_nettype wire
